FILE: hw/rtl/pmad_pkg.sv
package pmad_pkg;

  localparam int ALPHABET_DEPTH = 64;
  localparam int AW = $clog2(ALPHABET_DEPTH);
  localparam int LEN_CAP = (ALPHABET_DEPTH < 63) ? ALPHABET_DEPTH : 63;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [5:0] CODE_INDEX_MASK = 6'h3F;
  localparam int MERGE_BIT_POS = 6;
  localparam int WORD_END_BIT_POS = 7;

  // one classified code byte
  typedef struct packed {
    logic          stream_end;
    logic          err_first;
    logic          merge;
    logic          err_second;
    logic [AW-1:0] addr;
    logic          word_end;
  } pmad_entry_t;

  // alphabet write port
  typedef struct packed {
    logic          en;
    logic [AW-1:0] addr;
    logic [7:0]    data;
  } pmad_wr_t;

endpackage

FILE: hw/rtl/pmad_if.sv
interface pmad_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] stream_byte;

  modport source (output valid, output stream_byte, input ready);
  modport sink (input valid, input stream_byte, output ready);
endinterface

interface pmad_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       word_end;
  logic       last_of_item;
  logic       stream_end;
  logic       decode_error;

  modport source (output valid, output character, output word_end, output last_of_item,
                  output stream_end, output decode_error, input ready);
  modport sink (input valid, input character, input word_end, input last_of_item,
                input stream_end, input decode_error, output ready);
endinterface

FILE: hw/rtl/pmad_ram.sv
module pmad_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [WIDTH-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [WIDTH-1:0]         rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/pmad_front.sv
module pmad_front
  import pmad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  pmad_in_if.sink     in_if,
  input  logic        queue_full_i,
  input  logic        queue_empty_i,
  output logic        push_o,
  output pmad_entry_t entry_o,
  output pmad_wr_t    wr_o
);

  localparam logic [1:0] PH_HEADER = 2'd0;
  localparam logic [1:0] PH_LOAD   = 2'd1;
  localparam logic [1:0] PH_CODES  = 2'd2;

  logic [1:0] phase_q, phase_d;
  logic [5:0] len_q, len_d;
  logic [5:0] pos_q, pos_d;
  logic       accept;
  logic [7:0] b;
  logic [5:0] code;
  logic [5:0] hdr_len;
  logic [5:0] pos_next;

  assign b    = in_if.stream_byte;
  assign code = b[5:0] & CODE_INDEX_MASK;

  // alphabet writes wait until queued codes have done their reads
  always_comb begin
    case (phase_q)
      PH_LOAD:  in_if.ready = queue_empty_i;
      PH_CODES: in_if.ready = !queue_full_i;
      default:  in_if.ready = 1'b1;
    endcase
  end

  assign accept   = in_if.valid && in_if.ready;
  assign hdr_len  = (b > 8'(LEN_CAP)) ? 6'(LEN_CAP) : b[5:0];
  assign pos_next = pos_q + 6'd1;

  always_comb begin
    phase_d = phase_q;
    len_d   = len_q;
    pos_d   = pos_q;
    push_o  = 1'b0;
    wr_o.en   = 1'b0;
    wr_o.addr = pos_q[AW-1:0];
    wr_o.data = b;
    entry_o.stream_end = (b == 8'd0);
    entry_o.err_first  = (code == 6'd0) || (code > len_q);
    entry_o.merge      = b[MERGE_BIT_POS] && !entry_o.err_first;
    entry_o.err_second = (code >= len_q);
    entry_o.addr       = AW'(code - 6'd1);
    entry_o.word_end   = b[WORD_END_BIT_POS];
    if (accept) begin
      case (phase_q)
        PH_LOAD: begin
          wr_o.en = ({1'b0, pos_q} < 7'(ALPHABET_DEPTH));
          pos_d   = pos_next;
          if (pos_next >= len_q) begin
            phase_d = PH_CODES;
          end
        end
        PH_CODES: begin
          push_o = 1'b1;
          if (b == 8'd0) begin
            phase_d = PH_HEADER;
          end
        end
        default: begin
          len_d   = hdr_len;
          pos_d   = 6'd0;
          phase_d = (hdr_len == 6'd0) ? PH_CODES : PH_LOAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      len_q   <= 6'd0;
      pos_q   <= 6'd0;
    end else begin
      phase_q <= phase_d;
      len_q   <= len_d;
      pos_q   <= pos_d;
    end
  end

endmodule

FILE: hw/rtl/pmad_queue.sv
module pmad_queue
  import pmad_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  pmad_entry_t entry_i,
  input  logic        pop_i,
  output pmad_entry_t head_o,
  output logic        full_o,
  output logic        empty_o
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  pmad_entry_t     mem_q [QUEUE_DEPTH];
  logic [PW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [PW:0]     count_q;
  logic            do_push, do_pop;

  assign full_o  = (count_q == (PW+1)'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= PW'(wr_ptr_q + 1'b1);
      end
      if (do_pop) begin
        rd_ptr_q <= PW'(rd_ptr_q + 1'b1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: hw/rtl/pmad_back.sv
module pmad_back
  import pmad_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pmad_entry_t   head_i,
  input  logic          empty_i,
  output logic          pop_o,
  output logic          rd_en_o,
  output logic [AW-1:0] rd_addr_o,
  input  logic [7:0]    rd_data_i,
  pmad_out_if.source    out_if
);

  logic second_q;
  logic out_valid_q;
  logic use_ram_q;
  logic word_end_q, last_q, stream_end_q, err_q;

  logic adv, fire, merge_first;
  logic use_ram, word_end, last, err;

  assign adv         = !out_valid_q || out_if.ready;
  assign fire        = !empty_i && adv;
  assign merge_first = head_i.merge && !second_q;
  assign pop_o       = fire && !merge_first;

  // one result beat per cycle while out_if.ready holds; a merged code spends two beats
  always_comb begin
    use_ram   = 1'b0;
    word_end  = head_i.word_end;
    last      = 1'b1;
    err       = 1'b0;
    rd_addr_o = head_i.addr;
    if (head_i.stream_end) begin
      word_end = 1'b0;
    end else if (head_i.err_first) begin
      err = 1'b1;
    end else if (merge_first) begin
      use_ram  = 1'b1;
      word_end = 1'b0;
      last     = 1'b0;
    end else if (head_i.merge) begin
      rd_addr_o = AW'(head_i.addr + 1'b1);
      use_ram   = !head_i.err_second;
      err       = head_i.err_second;
    end else begin
      use_ram = 1'b1;
    end
  end

  assign rd_en_o = fire && use_ram;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      second_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        second_q <= merge_first;
      end
      if (adv) begin
        out_valid_q <= !empty_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      use_ram_q    <= use_ram;
      word_end_q   <= word_end;
      last_q       <= last;
      stream_end_q <= head_i.stream_end;
      err_q        <= err;
    end
  end

  assign out_if.valid        = out_valid_q;
  assign out_if.character    = use_ram_q ? rd_data_i : 8'd0;
  assign out_if.word_end     = word_end_q;
  assign out_if.last_of_item = last_q;
  assign out_if.stream_end   = stream_end_q;
  assign out_if.decode_error = err_q;

endmodule

FILE: hw/rtl/pair_merged_alphabet_decoder_core.sv
// pair merged alphabet decoder
// in_if carries one stream byte per beat: a header byte with the alphabet
// length (saturated to 63), that many alphabet bytes, then code bytes until
// a zero byte closes the stream and the next byte is a header again.
// out_if carries one character per beat with word_end, last_of_item,
// stream_end and decode_error; a plain code gives one beat, a merged code
// (bit 6) gives two, header and alphabet bytes give none.
// a front stage classifies code bytes and pushes them into a two-entry
// queue; a back stage reads the alphabet ram (registered read) and fills
// the output register, one result beat per cycle while out_if.ready holds.
// a code byte is registered in the queue, then in the output register.
// throughput: one code byte per cycle while out_if.ready holds; a merged
// code takes two beats of the single result channel and ram read port.
// alphabet bytes are taken one per cycle once the queue has drained.
// reset clears the parse state to header and empties queue and output.
// when the receiver stalls the output holds, the queue fills and then
// in_if.ready drops; no beat is lost.
module pair_merged_alphabet_decoder_core
  import pmad_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  pmad_in_if.sink    in_if,
  pmad_out_if.source out_if
);

  pmad_entry_t   push_entry, head;
  pmad_wr_t      wr;
  logic          push, pop, full, empty;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;

  pmad_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_if         (in_if),
    .queue_full_i  (full),
    .queue_empty_i (empty),
    .push_o        (push),
    .entry_o       (push_entry),
    .wr_o          (wr)
  );

  pmad_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .head_o  (head),
    .full_o  (full),
    .empty_o (empty)
  );

  pmad_ram #(
    .WIDTH (8),
    .DEPTH (ALPHABET_DEPTH)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr.en),
    .wr_addr_i (wr.addr),
    .wr_data_i (wr.data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  pmad_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .head_i    (head),
    .empty_i   (empty),
    .pop_o     (pop),
    .rd_en_o   (rd_en),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .out_if    (out_if)
  );

endmodule

FILE: hw/rtl/pmad_checker.sv
module pmad_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] character_i,
  input logic       word_end_i,
  input logic       last_of_item_i,
  input logic       stream_end_i,
  input logic       decode_error_i
);

  // a stream end beat is a lone zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && stream_end_i |->
      character_i == 8'd0 && last_of_item_i && !word_end_i && !decode_error_i)
    else $error("bad stream end beat");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && decode_error_i |-> character_i == 8'd0 && !stream_end_i)
    else $error("error beat carries a character");

  // the second beat of a merged code follows right away
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_ready_i && !last_of_item_i |=> out_valid_i && !stream_end_i)
    else $error("merged pair broken");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(character_i)
      && $stable(last_of_item_i) && $stable(decode_error_i))
    else $error("stalled beat changed");

endmodule

bind pair_merged_alphabet_decoder_core pmad_checker u_pmad_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .character_i    (out_if.character),
  .word_end_i     (out_if.word_end),
  .last_of_item_i (out_if.last_of_item),
  .stream_end_i   (out_if.stream_end),
  .decode_error_i (out_if.decode_error)
);
